### design/pfcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcr_pkg
// Shared types, constants and helpers for the Pareto front crowding ranker.
// ----------------------------------------------------------------------------
package pfcr_pkg;

    // largest population the store can ever hold
    localparam int STORE_MAX    = 64;
    localparam int DEF_MEMBERS  = 32;
    // fixed widths that cover every legal population size
    localparam int SLOT_W       = 6;
    localparam int COUNT_W      = 7;
    localparam int OBJ_W        = 32;
    localparam int DIST_W       = 33;
    localparam int FRONT_W      = 6;
    // depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;

    // one classified item handed from the front to the back
    typedef struct packed {
        logic signed [OBJ_W-1:0] obj1;
        logic signed [OBJ_W-1:0] obj2;
        logic [SLOT_W-1:0]       slot;
        logic [COUNT_W-1:0]      count;
        logic                    store;
        logic                    last;
        logic                    ovf;
    } pfcr_item_t;

    // back part sequencer states
    typedef enum logic [3:0] {
        B_LOAD,
        B_SRT_RDP,
        B_SRT_LDP,
        B_SRT_RDQ,
        B_SRT_CMP,
        B_SRT_WR,
        B_DOM_RDP,
        B_DOM_LDP,
        B_DOM_RDQ,
        B_DOM_CMP,
        B_EM_RD,
        B_EM_CHK,
        B_EM_DIF,
        B_EM_OUT,
        B_EM_END
    } pfcr_state_t;

    // q dominates p when no worse in both and strictly better in one
    function automatic logic beats(input logic signed [OBJ_W-1:0] q1,
                                   input logic signed [OBJ_W-1:0] q2,
                                   input logic signed [OBJ_W-1:0] p1,
                                   input logic signed [OBJ_W-1:0] p2);
        return ((q1 < p1) && (q2 <= p2)) || ((q2 < p2) && (q1 <= p1));
    endfunction

    // exact magnitude of the difference of two signed values
    function automatic logic [OBJ_W-1:0] absdiff(input logic signed [OBJ_W-1:0] a,
                                                 input logic signed [OBJ_W-1:0] b);
        logic [OBJ_W:0] d;
        logic [OBJ_W:0] nd;
        d  = {a[OBJ_W-1], a} - {b[OBJ_W-1], b};
        nd = -d;
        return d[OBJ_W] ? nd[OBJ_W-1:0] : d[OBJ_W-1:0];
    endfunction

endpackage

### design/pfcr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcr_front
// Accepts members, assigns store slots, drops those beyond capacity.
// ----------------------------------------------------------------------------
module pfcr_front
    import pfcr_pkg::*;
#(
    parameter int MAX_MEMBERS = DEF_MEMBERS
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // objective_one, objective_two
    input  logic        s_axis_tlast,   // last_member
    output logic        push,
    output pfcr_item_t  push_item,
    input  logic        full
);

    localparam int CNT_W = $clog2(MAX_MEMBERS + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             store;

    // classify the request
    always_comb
    begin
        s_axis_tready    = !full;
        push             = s_axis_tvalid && !full;
        store            = (count_reg < CNT_W'(MAX_MEMBERS));
        push_item.obj1   = s_axis_tdata[31:0];
        push_item.obj2   = s_axis_tdata[63:32];
        push_item.slot   = SLOT_W'(count_reg);
        push_item.count  = store ? COUNT_W'(count_reg + CNT_W'(1)) : COUNT_W'(count_reg);
        push_item.store  = store;
        push_item.last   = s_axis_tlast;
        push_item.ovf    = ovf_reg || !store;
        count_next       = count_reg;
        ovf_next         = ovf_reg;
        if (push)
        begin
            if (s_axis_tlast)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                count_next = store ? count_reg + CNT_W'(1) : count_reg;
                ovf_next   = push_item.ovf;
            end
        end
    end

    // fill count and drop flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

### design/pfcr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcr_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module pfcr_queue
    import pfcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pfcr_item_t push_item,
    output logic       full,
    output logic       pop_valid,
    output pfcr_item_t pop_item,
    input  logic       pop
);

    pfcr_item_t          q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     fill_reg;
    logic                do_pop;

    // status
    always_comb
    begin
        full      = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
        pop_valid = (fill_reg != '0);
        pop_item  = q_mem[rd_ptr_reg];
        do_pop    = pop && pop_valid;
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !do_pop)
            begin
                fill_reg <= fill_reg + (QPTR_W+1)'(1);
            end
            else if (!push && do_pop)
            begin
                fill_reg <= fill_reg - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

### design/pfcr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcr_back
// Stores members, sorts by objective one, peels fronts, emits crowding.
// ----------------------------------------------------------------------------
module pfcr_back
    import pfcr_pkg::*;
#(
    parameter int MAX_MEMBERS = DEF_MEMBERS
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    input  pfcr_item_t  pop_item,
    output logic        pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // member_index, front_number, crowding_distance
    output logic [1:0]  m_axis_tuser,   // crowding_infinite, overflowed
    output logic        m_axis_tlast    // last_of_run
);

    localparam int IDX_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
    localparam int SO_W  = IDX_W + 2 * OBJ_W;

    // memories
    logic [2*OBJ_W-1:0] st_mem [MAX_MEMBERS];
    logic [SO_W-1:0]    so_mem [MAX_MEMBERS];
    logic [2*OBJ_W-1:0] st_rd_reg;
    logic [SO_W-1:0]    so_rd_reg;
    logic               st_we, so_we;
    logic [IDX_W-1:0]   st_wa, st_ra, so_ra;
    logic [SO_W-1:0]    so_wd;

    pfcr_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   n_reg, n_next, i_reg, i_next, j_reg, j_next, left_reg, left_next;
    logic [IDX_W-1:0]   rank_reg, rank_next;
    logic               ovf_reg, ovf_next;
    logic signed [OBJ_W-1:0] p1_reg, p1_next, p2_reg, p2_next;
    logic [MAX_MEMBERS-1:0]  dom_reg, dom_next, asg_reg, asg_next;
    logic [FRONT_W-1:0] front_reg, front_next;
    // crowding window: previous, current and next member
    logic signed [OBJ_W-1:0] pv1_reg, pv1_next, pv2_reg, pv2_next;
    logic signed [OBJ_W-1:0] cu1_reg, cu1_next, cu2_reg, cu2_next;
    logic signed [OBJ_W-1:0] nx1_reg, nx1_next, nx2_reg, nx2_next;
    logic [IDX_W-1:0]   cui_reg, cui_next, nxi_reg, nxi_next;
    logic               have_reg, have_next, first_reg, first_next;
    logic [OBJ_W-1:0]   d1_reg, d1_next, d2_reg, d2_next;
    // output register
    logic               ov_reg, ov_next, ol_reg, ol_next, oinf_reg, oinf_next;
    logic [IDX_W-1:0]   oidx_reg, oidx_next;
    logic [FRONT_W-1:0] ofr_reg, ofr_next;
    logic [DIST_W-1:0]  odist_reg, odist_next;
    logic               oovf_reg, oovf_next;

    logic               i_last, j_last, out_free;
    logic [IDX_W-1:0]   ii, jj;
    logic signed [OBJ_W-1:0] s1, s2, so1, so2;
    logic [IDX_W-1:0]   soi;

    // memory ports with registered read
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_wa] <= {pop_item.obj1, pop_item.obj2};
        end
        if (so_we)
        begin
            so_mem[rank_reg] <= so_wd;
        end
        st_rd_reg <= st_mem[st_ra];
        so_rd_reg <= so_mem[so_ra];
    end

    // read data fields
    always_comb
    begin
        s1  = st_rd_reg[2*OBJ_W-1:OBJ_W];
        s2  = st_rd_reg[OBJ_W-1:0];
        so1 = so_rd_reg[2*OBJ_W-1:OBJ_W];
        so2 = so_rd_reg[OBJ_W-1:0];
        soi = so_rd_reg[SO_W-1:2*OBJ_W];
        ii  = i_reg[IDX_W-1:0];
        jj  = j_reg[IDX_W-1:0];
        i_last   = (i_reg + CNT_W'(1) == n_reg);
        j_last   = (j_reg + CNT_W'(1) == n_reg);
        out_free = !ov_reg || m_axis_tready;
    end

    // sequencer: next state and datapath
    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;   i_next = i_reg;   j_next = j_reg;   left_next = left_reg;
        rank_next = rank_reg;   ovf_next = ovf_reg;
        p1_next = p1_reg;   p2_next = p2_reg;
        dom_next = dom_reg;   asg_next = asg_reg;   front_next = front_reg;
        pv1_next = pv1_reg;   pv2_next = pv2_reg;
        cu1_next = cu1_reg;   cu2_next = cu2_reg;   cui_next = cui_reg;
        nx1_next = nx1_reg;   nx2_next = nx2_reg;   nxi_next = nxi_reg;
        have_next = have_reg;   first_next = first_reg;
        d1_next = d1_reg;   d2_next = d2_reg;
        ov_next = ov_reg && !m_axis_tready;
        ol_next = ol_reg;   oinf_next = oinf_reg;   oidx_next = oidx_reg;
        ofr_next = ofr_reg;   odist_next = odist_reg;   oovf_next = oovf_reg;
        pop   = 1'b0;
        st_we = 1'b0;
        st_wa = IDX_W'(pop_item.slot);
        st_ra = ii;
        so_we = 1'b0;
        so_ra = ii;
        so_wd = {ii, p1_reg, p2_reg};
        unique case (state_reg)
            // take members from the queue into the store
            B_LOAD:
            begin
                pop = 1'b1;
                if (pop_valid)
                begin
                    st_we = pop_item.store;
                    if (pop_item.last)
                    begin
                        n_next     = CNT_W'(pop_item.count);
                        ovf_next   = pop_item.ovf;
                        i_next     = '0;
                        state_next = B_SRT_RDP;
                    end
                end
            end
            // rank member i by objective one, ties by load order
            B_SRT_RDP:
            begin
                state_next = B_SRT_LDP;
            end
            B_SRT_LDP:
            begin
                p1_next    = s1;
                p2_next    = s2;
                j_next     = '0;
                rank_next  = '0;
                state_next = B_SRT_RDQ;
            end
            B_SRT_RDQ:
            begin
                st_ra      = jj;
                state_next = B_SRT_CMP;
            end
            B_SRT_CMP:
            begin
                if ((s1 < p1_reg) || ((s1 == p1_reg) && (j_reg < i_reg)))
                begin
                    rank_next = rank_reg + IDX_W'(1);
                end
                j_next     = j_reg + CNT_W'(1);
                state_next = j_last ? B_SRT_WR : B_SRT_RDQ;
            end
            B_SRT_WR:
            begin
                so_we = 1'b1;
                if (i_last)
                begin
                    i_next     = '0;
                    left_next  = n_reg;
                    front_next = '0;
                    state_next = B_DOM_RDP;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = B_SRT_RDP;
                end
            end
            // mark dominated members among those still unassigned
            B_DOM_RDP:
            begin
                if (asg_reg[ii])
                begin
                    if (i_last)
                    begin
                        i_next     = '0;
                        have_next  = 1'b0;
                        state_next = B_EM_RD;
                    end
                    else
                    begin
                        i_next = i_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = B_DOM_LDP;
                end
            end
            B_DOM_LDP:
            begin
                p1_next     = so1;
                p2_next     = so2;
                dom_next[ii] = 1'b0;
                j_next      = '0;
                state_next  = B_DOM_RDQ;
            end
            B_DOM_RDQ:
            begin
                so_ra      = jj;
                state_next = B_DOM_CMP;
            end
            B_DOM_CMP:
            begin
                if (!asg_reg[jj] && beats(so1, so2, p1_reg, p2_reg))
                begin
                    dom_next[ii] = 1'b1;
                end
                j_next = j_reg + CNT_W'(1);
                if (!j_last)
                begin
                    state_next = B_DOM_RDQ;
                end
                else if (i_last)
                begin
                    i_next     = '0;
                    have_next  = 1'b0;
                    state_next = B_EM_RD;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = B_DOM_RDP;
                end
            end
            // walk the front in sorted order
            B_EM_RD:
            begin
                if (asg_reg[ii] || dom_reg[ii])
                begin
                    if (i_last)
                    begin
                        state_next = B_EM_END;
                    end
                    else
                    begin
                        i_next = i_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = B_EM_CHK;
                end
            end
            B_EM_CHK:
            begin
                asg_next[ii] = 1'b1;
                left_next    = left_reg - CNT_W'(1);
                if (!have_reg)
                begin
                    cu1_next   = so1;
                    cu2_next   = so2;
                    cui_next   = soi;
                    have_next  = 1'b1;
                    first_next = 1'b1;
                    if (i_last)
                    begin
                        state_next = B_EM_END;
                    end
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = B_EM_RD;
                    end
                end
                else
                begin
                    nx1_next   = so1;
                    nx2_next   = so2;
                    nxi_next   = soi;
                    state_next = B_EM_DIF;
                end
            end
            B_EM_DIF:
            begin
                d1_next    = absdiff(pv1_reg, nx1_reg);
                d2_next    = absdiff(pv2_reg, nx2_reg);
                state_next = B_EM_OUT;
            end
            // emit the current member once its successor is known
            B_EM_OUT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ol_next    = 1'b0;
                    oinf_next  = first_reg;
                    oidx_next  = cui_reg;
                    ofr_next   = front_reg;
                    odist_next = first_reg ? '0 : DIST_W'(d1_reg) + DIST_W'(d2_reg);
                    oovf_next  = ovf_reg;
                    pv1_next   = cu1_reg;
                    pv2_next   = cu2_reg;
                    cu1_next   = nx1_reg;
                    cu2_next   = nx2_reg;
                    cui_next   = nxi_reg;
                    first_next = 1'b0;
                    if (i_last)
                    begin
                        state_next = B_EM_END;
                    end
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = B_EM_RD;
                    end
                end
            end
            // last member of the front, then next front or done
            B_EM_END:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ol_next    = (left_reg == '0);
                    oinf_next  = 1'b1;
                    oidx_next  = cui_reg;
                    ofr_next   = front_reg;
                    odist_next = '0;
                    oovf_next  = ovf_reg;
                    front_next = front_reg + FRONT_W'(1);
                    i_next     = '0;
                    if (left_reg == '0)
                    begin
                        asg_next   = '0;
                        dom_next   = '0;
                        state_next = B_LOAD;
                    end
                    else
                    begin
                        state_next = B_DOM_RDP;
                    end
                end
            end
            default:
            begin
                state_next = B_LOAD;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_LOAD;
            n_reg <= '0;   i_reg <= '0;   j_reg <= '0;   left_reg <= '0;
            rank_reg <= '0;   ovf_reg <= 1'b0;
            dom_reg <= '0;   asg_reg <= '0;   front_reg <= '0;
            have_reg <= 1'b0;   first_reg <= 1'b0;
            ov_reg <= 1'b0;   ol_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg <= n_next;   i_reg <= i_next;   j_reg <= j_next;   left_reg <= left_next;
            rank_reg <= rank_next;   ovf_reg <= ovf_next;
            dom_reg <= dom_next;   asg_reg <= asg_next;   front_reg <= front_next;
            have_reg <= have_next;   first_reg <= first_next;
            ov_reg <= ov_next;   ol_reg <= ol_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        p1_reg <= p1_next;   p2_reg <= p2_next;
        pv1_reg <= pv1_next;   pv2_reg <= pv2_next;
        cu1_reg <= cu1_next;   cu2_reg <= cu2_next;   cui_reg <= cui_next;
        nx1_reg <= nx1_next;   nx2_reg <= nx2_next;   nxi_reg <= nxi_next;
        d1_reg <= d1_next;   d2_reg <= d2_next;
        oinf_reg <= oinf_next;   oidx_reg <= oidx_next;   ofr_reg <= ofr_next;
        odist_reg <= odist_next;   oovf_reg <= oovf_next;
    end

    // result port
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {3'b000, odist_reg, ofr_reg, SLOT_W'(oidx_reg)};
    assign m_axis_tuser  = {oovf_reg, oinf_reg};
    assign m_axis_tlast  = ol_reg;

`ifndef SYNTHESIS
    // no member stays marked assigned between populations
    a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_LOAD) |-> (asg_reg == '0))
        else $error("assigned flags not cleared while loading");
    // walk position stays inside the population
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_LOAD) |-> (i_reg < n_reg))
        else $error("walk position beyond population");
    // members still to rank never exceed the population
    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_LOAD) |-> (left_reg <= n_reg))
        else $error("remaining count exceeds population");
    // a new result is only loaded into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !m_axis_tready) |=> (ov_reg && $stable(odist_reg)))
        else $error("pending result overwritten");
`endif

endmodule

### design/pareto_front_crowding_ranker_top.sv
`timescale 1ns / 1ps
// Order: while the back part is loading, a member is written into a queue entry and then
// into the store; after the last member, the back part sorts the population, then for
// each front marks the dominated members and emits the members of the front.
// Throughput: one member per cycle while loading; the back part ranks one
// population at a time, with one read a cycle from its store and sorted-order memories.
// Reset: rst_n clears fill count, queue, sequencer and all member flags at once.
// ----------------------------------------------------------------------------
// pareto_front_crowding_ranker_top
// Pareto front peeling with crowding distance over a loaded population.
// ----------------------------------------------------------------------------
module pareto_front_crowding_ranker_top
    import pfcr_pkg::*;
#(
    parameter int MAX_MEMBERS = DEF_MEMBERS
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // objective_one, objective_two
    input  logic        s_axis_tlast,   // last_member
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // member_index, front_number, crowding_distance
    output logic [1:0]  m_axis_tuser,   // crowding_infinite, overflowed
    output logic        m_axis_tlast    // last_of_run
);

    logic       push, full, pop_valid, pop;
    pfcr_item_t push_item, pop_item;

    // accept and classify
    pfcr_front #(.MAX_MEMBERS(MAX_MEMBERS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .push(push), .push_item(push_item), .full(full)
    );

    // decoupling queue
    pfcr_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_item(push_item), .full(full),
        .pop_valid(pop_valid), .pop_item(pop_item), .pop(pop)
    );

    // store, sort, peel and emit
    pfcr_back #(.MAX_MEMBERS(MAX_MEMBERS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .pop_valid(pop_valid), .pop_item(pop_item), .pop(pop),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

endmodule
